// ===== rtl/core/tcp_congestion_window_update_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the congestion window update block
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TCP_CONGESTION_WINDOW_UPDATE_DEFINES_SVH
`define TCP_CONGESTION_WINDOW_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define TCWU_ASSERT_HOLDS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tcwu assertion failed");

// expression must never be true outside reset
`define TCWU_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("tcwu forbidden condition seen");

`else

`define TCWU_ASSERT_HOLDS(lbl, prop)
`define TCWU_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ===== rtl/core/tcwu_pkg.sv =====
// ----------------------------------------------------------------------------
// tcwu_pkg
// Shared types and constants of the congestion window update block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcwu_pkg;

   localparam logic [31:0] WMAX                = 32'hFFFF_FFFF;
   localparam logic [15:0] SEG_SIZE_RST        = 16'd1448;
   localparam logic [31:0] START_WINDOW_RST    = 32'd1;
   localparam logic [31:0] START_THRESHOLD_RST = 32'd65535;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_SIZE = 2'd0;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // controller to datapath
   typedef struct packed {
      logic load;
      logic loss;
      logic round_inc;
      logic pow_set;
      logic mul_lo;
      logic mul_hi;
      logic mul_add;
      logic shift;
      logic apply;
      logic div_init;
      logic div_step;
      logic add_set;
      logic out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_loss;
      logic in_slow;
      logic acked_zero;
      logic pow_ok;
      logic avoid_needed;
   } dp_status_type;

   typedef struct packed {
      logic [31:0] window;
      logic [31:0] threshold;
      logic [15:0] leftover_acked;
      logic        phase;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/tcwu_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcwu_ctrl
// Sequencer: walks one event through loss, slow start, multiply, divide steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwu_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  tcwu_pkg::dp_status_type status,
   input  wire                     out_free,
   output tcwu_pkg::dp_cmd_type    cmd
);
   import tcwu_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EVAL  = 4'd1;
   localparam logic [3:0] S_SS    = 4'd2;
   localparam logic [3:0] S_MHI   = 4'd3;
   localparam logic [3:0] S_MADD  = 4'd4;
   localparam logic [3:0] S_SHIFT = 4'd5;
   localparam logic [3:0] S_APPLY = 4'd6;
   localparam logic [3:0] S_AVCHK = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_ADD   = 4'd9;
   localparam logic [3:0] S_FIN   = 4'd10;

   logic [3:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.is_loss) begin
               cmd.loss = 1'b1;
               state_in = S_FIN;
            end else if (status.in_slow) begin
               cmd.round_inc = 1'b1;
               state_in      = S_SS;
            end else begin
               state_in = S_AVCHK;
            end
         end
         S_SS: begin
            if (status.acked_zero) begin
               state_in = S_AVCHK;
            end else if (status.pow_ok) begin
               cmd.pow_set = 1'b1;
               state_in    = S_AVCHK;
            end else begin
               cmd.mul_lo = 1'b1;
               state_in   = S_MHI;
            end
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_MADD;
         end
         S_MADD: begin
            cmd.mul_add = 1'b1;
            state_in    = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_AVCHK;
         end
         S_AVCHK: begin
            if (status.avoid_needed) begin
               cmd.div_init = 1'b1;
               div_cnt_in   = '0;
               state_in     = S_DIV;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               div_cnt_in = '0;
               state_in   = S_ADD;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_ADD: begin
            cmd.add_set = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            // hold until the result register can take the beat
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tcwu_dpath.sv =====
// ----------------------------------------------------------------------------
// tcwu_dpath
// Window state, shared 33x16 multiplier, shifter and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tcwu_dpath (
   input  wire                              clock,
   input  wire                              reset,
   input  tcwu_pkg::dp_cmd_type             cmd,
   input  wire                              req_action,
   input  wire  [15:0]                      req_acked_segments,
   input  wire  [31:0]                      req_in_flight_bytes,
   input  wire                              csr_we,
   input  wire  [tcwu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [31:0]                      csr_wdata,
   output tcwu_pkg::dp_status_type          status,
   output tcwu_pkg::result_type             result
);
   import tcwu_pkg::*;

   // window and threshold presets load at reset, where both presets hold
   // their reset values, so only the segment size is kept
   logic [15:0] seg_ff, seg_in;

   logic [31:0] cwnd_ff, cwnd_in;
   logic [31:0] ssth_ff, ssth_in;
   logic [31:0] rc_ff, rc_in;

   logic        action_ff, action_in;
   logic [31:0] flight_ff, flight_in;
   logic [15:0] left_ff, left_in;
   logic        phase_ff, phase_in;

   logic [48:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;

   logic [32:0] t_val;
   logic [30:0] t_quart;
   logic [31:0] half;
   logic [15:0] mul_b;
   logic [32:0] diff;
   logic [32:0] div_shifted;
   logic [32:0] div_sub;
   logic        div_ge;
   logic [31:0] add_val;
   logic [32:0] add_sum;
   logic [31:0] loss_a;
   logic [31:0] loss_b;

   assign t_val   = {1'b0, ssth_ff} + 33'd1;
   assign t_quart = t_val[32:2];
   assign half    = t_val[32:1];
   assign mul_b   = cmd.mul_lo ? t_quart[15:0] : {1'b0, t_quart[30:16]};

   assign diff        = (acc_ff >= {31'b0, t_val}) ? 33'd0 : (t_val - acc_ff[32:0]);
   assign div_shifted = {rem_ff, quo_ff[31]};
   assign div_ge      = (div_shifted >= {1'b0, cwnd_ff});
   assign div_sub     = div_shifted - {1'b0, cwnd_ff};
   assign add_val     = (quo_ff == 32'd0) ? 32'd1 : quo_ff;
   assign add_sum     = {1'b0, cwnd_ff} + {1'b0, add_val};
   assign loss_a      = {15'b0, seg_ff, 1'b0};
   assign loss_b      = {1'b0, flight_ff[31:1]};

   always_comb begin
      status.is_loss      = action_ff;
      status.in_slow      = (cwnd_ff < ssth_ff);
      status.acked_zero   = (left_ff == 16'd0);
      status.pow_ok       = (rc_ff[31:5] == 27'd0) && ((32'd1 << rc_ff[4:0]) <= half);
      status.avoid_needed = (cwnd_ff >= ssth_ff) && (left_ff != 16'd0);
   end

   always_comb begin
      result.window         = cwnd_ff;
      result.threshold      = ssth_ff;
      result.leftover_acked = left_ff;
      result.phase          = phase_ff;
   end

   always_comb begin
      seg_in    = seg_ff;
      cwnd_in   = cwnd_ff;
      ssth_in   = ssth_ff;
      rc_in     = rc_ff;
      action_in = action_ff;
      flight_in = flight_ff;
      left_in   = left_ff;
      phase_in  = phase_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;

      if (csr_we && (csr_index == CSR_SEGMENT_SIZE)) begin
         seg_in = csr_wdata[15:0];
      end

      if (cmd.load) begin
         action_in = req_action;
         flight_in = req_in_flight_bytes;
         left_in   = req_action ? 16'd0 : req_acked_segments;
         phase_in  = 1'b1;
      end
      if (cmd.loss) begin
         ssth_in = (loss_a > loss_b) ? loss_a : loss_b;
      end
      if (cmd.round_inc) begin
         rc_in    = rc_ff + 32'd1;
         phase_in = 1'b0;
      end
      if (cmd.pow_set) begin
         cwnd_in = 32'd1 << rc_ff[4:0];
         left_in = left_ff - 16'd1;
      end
      // two partial products of t * (t/4), low half first
      if (cmd.mul_lo || cmd.mul_hi) begin
         prod_in = {16'b0, t_val} * {33'b0, mul_b};
      end
      if (cmd.mul_lo) begin
         left_in = left_ff - 16'd1;
      end
      if (cmd.mul_hi) begin
         acc_in = {15'b0, prod_ff};
      end
      if (cmd.mul_add) begin
         acc_in = acc_ff + {prod_ff[47:0], 16'b0};
      end
      if (cmd.shift) begin
         acc_in = (rc_ff[31:6] != 26'd0) ? 64'd0 : (acc_ff >> rc_ff[5:0]);
      end
      if (cmd.apply) begin
         cwnd_in = diff[32] ? WMAX : diff[31:0];
      end
      if (cmd.div_init) begin
         rem_in = 32'd0;
         quo_in = {16'b0, seg_ff} * {16'b0, seg_ff};
      end
      // one quotient bit per step; a zero divisor yields all ones
      if (cmd.div_step) begin
         rem_in = div_ge ? div_sub[31:0] : div_shifted[31:0];
         quo_in = {quo_ff[30:0], div_ge};
      end
      if (cmd.add_set) begin
         cwnd_in = add_sum[32] ? WMAX : add_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff  <= SEG_SIZE_RST;
         cwnd_ff <= START_WINDOW_RST;
         ssth_ff <= START_THRESHOLD_RST;
         rc_ff   <= 32'd0;
      end else begin
         seg_ff  <= seg_in;
         cwnd_ff <= cwnd_in;
         ssth_ff <= ssth_in;
         rc_ff   <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      flight_ff <= flight_in;
      left_ff   <= left_in;
      phase_ff  <= phase_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/tcp_congestion_window_update.sv =====
// ----------------------------------------------------------------------------
// tcp_congestion_window_update
// Congestion window, slow start threshold and round counter per ACK/loss.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, acked_segments, in_flight
//   rsp      out        rsp_valid/rsp_stall  window, threshold, leftover, phase
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One event is worked on at a time. A loss passes load, evaluation and the
// finish state; an ACK adds slow start and the multiply, shift and apply
// steps as needed, and growth in avoidance the 32-step restoring divider.
// Reset is synchronous; it loads the window presets and clears the counter.
// A stalled result waits in the output register while the next beat is
// taken; the sequencer holds only if it finishes before that slot frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_congestion_window_update_defines.svh"

module tcp_congestion_window_update (
   input  wire                             clock,
   input  wire                             reset,

   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire                             req_action,
   input  wire  [15:0]                     req_acked_segments,
   input  wire  [31:0]                     req_in_flight_bytes,

   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [31:0]                     rsp_window,
   output logic [31:0]                     rsp_threshold,
   output logic [15:0]                     rsp_leftover_acked,
   output logic                            rsp_phase,

   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [tcwu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [31:0]                     csr_wdata
);
   import tcwu_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   result_type    result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       out_free;
   logic       csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   tcwu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   tcwu_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_action          (req_action),
      .req_acked_segments  (req_acked_segments),
      .req_in_flight_bytes (req_in_flight_bytes),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .status              (status),
      .result              (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window         = rsp_data_ff.window;
   assign rsp_threshold      = rsp_data_ff.threshold;
   assign rsp_leftover_acked = rsp_data_ff.leftover_acked;
   assign rsp_phase          = rsp_data_ff.phase;

   // an accepted beat keeps the input stalled while it is worked on
   `TCWU_ASSERT_HOLDS(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall)
   // a finished result never overwrites one still waiting
   `TCWU_ASSERT_NEVER(a_no_overwrite, cmd.out_load && rsp_valid_ff && rsp_stall)
   // a result beat only appears after the sequencer loads it
   `TCWU_ASSERT_HOLDS(a_valid_from_load, $rose(rsp_valid_ff) |-> $past(cmd.out_load))

endmodule

`default_nettype wire
